@@ hw/rtl/rrdp_pkg.sv @@
// Package for the register reply datagram parser.
// Holds register indexes, status codes and the CRC8 byte step.
// No dependencies.
package rrdp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_BYTE      = 2'd0;
    localparam logic [1:0] CFG_MASTER_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_REG   = 2'd2;

    // Configuration reset values
    localparam logic [7:0] SYNC_BYTE_RST      = 8'd5;
    localparam logic [7:0] MASTER_ADDRESS_RST = 8'd255;
    localparam logic [6:0] EXPECTED_REG_RST   = 7'd0;

    // Reply status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    // Byte positions inside a datagram
    localparam logic [2:0] POS_HUNT    = 3'd0;
    localparam logic [2:0] POS_ADDRESS = 3'd1;
    localparam logic [2:0] POS_REG     = 3'd2;
    localparam logic [2:0] POS_CRC     = 3'd7;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // CRC8, poly 0x07, one byte taken LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/register_reply_datagram_parser.sv @@
// Register reply datagram parser: top level.
// Hunts for 8-byte register reply datagrams in a received byte stream.
// Depends on rrdp_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one received byte per
//   item in i_rx_byte, with i_new_request clearing the hunt before that byte.
//   Output channel (o_out_valid / i_out_stall) carries one result per
//   complete datagram: o_reg_value (data bytes, big-endian) and
//   o_reply_status (0 ok, 1 CRC mismatch). Other bytes give no result.
//   Configuration: i_cfg_we writes i_cfg_wdata to the register selected by
//   i_cfg_idx (0 sync byte, 1 master address, 2 expected register); write
//   only while the block is idle.
// Timing:
//   An item is taken into an input register, then checked and folded into
//   the hunt state and the result register once the result register is
//   free to take it. One item per cycle is sustained while no stalled result
//   holds the output; the CRC8 byte step is a single parallel update.
// Reset (synchronous, active low) restores the register defaults and empties
//   the hunt. A stalled result holds; the input register then stalls the
//   input channel once it is full as well.
module register_reply_datagram_parser
    import rrdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_new_request,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reply_status,
    output logic [31:0] o_reg_value
);

    // Configuration registers
    logic [7:0]  r_sync_byte;
    logic [7:0]  r_master_address;
    logic [6:0]  r_expected_reg;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_rx_byte;
    logic        r_new_req;

    // Hunt state
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_crc, n_crc;
    logic [31:0] r_data, n_data;

    // Result register
    logic        r_out_valid;
    logic        r_status, n_status;
    logic [31:0] r_value;

    logic        out_ready;
    logic        adv;
    logic        emit;
    logic [2:0]  cur_cnt;
    logic [7:0]  cur_crc;
    logic [31:0] cur_data;
    logic        is_sync;
    logic        drop;
    logic [7:0]  crc_seed;
    logic [7:0]  crc_new;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte      <= SYNC_BYTE_RST;
            r_master_address <= MASTER_ADDRESS_RST;
            r_expected_reg   <= EXPECTED_REG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_BYTE:      r_sync_byte      <= i_cfg_wdata;
                CFG_MASTER_ADDRESS: r_master_address <= i_cfg_wdata;
                CFG_EXPECTED_REG:   r_expected_reg   <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_rx_byte <= i_rx_byte;
            r_new_req <= i_new_request;
        end
    end

    // State as seen by this byte, after an optional new-request clear
    assign cur_cnt  = r_new_req ? POS_HUNT : r_cnt;
    assign cur_crc  = r_new_req ? 8'd0 : r_crc;
    assign cur_data = r_new_req ? 32'd0 : r_data;
    assign is_sync  = (r_rx_byte == r_sync_byte);

    // Candidate dropped on a wrong address or register byte
    always_comb begin
        case (cur_cnt)
            POS_ADDRESS: drop = (r_rx_byte != r_master_address);
            POS_REG:     drop = (r_rx_byte != {1'b0, r_expected_reg});
            default:     drop = 1'b0;
        endcase
    end

    // One shared CRC step; a fresh start seeds it with zero
    assign crc_seed = ((cur_cnt == POS_HUNT) || drop) ? 8'd0 : cur_crc;
    assign crc_new  = crc8_byte(crc_seed, r_rx_byte);

    // Next hunt state and result
    always_comb begin
        n_cnt    = cur_cnt;
        n_crc    = cur_crc;
        n_data   = cur_data;
        emit     = 1'b0;
        n_status = (r_rx_byte == cur_crc) ? STATUS_OK : STATUS_CRC_ERR;
        case (cur_cnt)
            POS_HUNT: begin
                if (is_sync) begin
                    n_cnt  = POS_ADDRESS;
                    n_crc  = crc_new;
                    n_data = 32'd0;
                end
            end
            POS_ADDRESS, POS_REG: begin
                if (drop) begin
                    n_cnt  = is_sync ? POS_ADDRESS : POS_HUNT;
                    n_crc  = is_sync ? crc_new : 8'd0;
                    n_data = 32'd0;
                end else begin
                    n_cnt = cur_cnt + 3'd1;
                    n_crc = crc_new;
                end
            end
            POS_CRC: begin
                emit   = 1'b1;
                n_cnt  = POS_HUNT;
                n_crc  = 8'd0;
                n_data = 32'd0;
            end
            default: begin
                n_cnt  = cur_cnt + 3'd1;
                n_crc  = crc_new;
                n_data = {cur_data[23:0], r_rx_byte};
            end
        endcase
    end

    // Hunt state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= POS_HUNT;
            r_crc  <= 8'd0;
            r_data <= 32'd0;
        end else if (adv) begin
            r_cnt  <= n_cnt;
            r_crc  <= n_crc;
            r_data <= n_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= adv && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_status <= n_status;
            r_value  <= cur_data;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reply_status = r_status;
    assign o_reg_value    = r_value;

    // Checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_emit_on_crc_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit) |-> (r_cnt == POS_CRC && !r_new_req))
        else $error("result issued outside the CRC byte");

    a_data_clear_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == POS_HUNT || r_cnt == POS_ADDRESS || r_cnt == POS_REG)
        |-> (r_data == 32'd0))
        else $error("data bytes held before the data field");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule

@@ test/tb_register_reply_datagram_parser.sv @@
`timescale 1ns / 1ps
// Testbench for register_reply_datagram_parser: random and directed byte streams with
// a byte-accurate hunt/CRC8 predictor checked against every reply item.
// Depends on rrdp_pkg and register_reply_datagram_parser.
module tb_register_reply_datagram_parser;
    import rrdp_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       req;
    } t_rx_item;

    typedef struct packed {
        logic        status;
        logic [31:0] value;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_SYNC_BYTE;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_new_request = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_reply_status;
    logic [31:0] o_reg_value;

    register_reply_datagram_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_new_request  (i_new_request),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_reply_status (o_reply_status),
        .o_reg_value    (o_reg_value)
    );

    // Configuration as the testbench believes it to be
    logic [7:0] cfg_sync = SYNC_BYTE_RST;
    logic [7:0] cfg_master = MASTER_ADDRESS_RST;
    logic [6:0] cfg_reg = EXPECTED_REG_RST;

    // Predicted hunt state
    logic [2:0]  hunt_len = POS_HUNT;
    logic [7:0]  hunt_crc = 8'h00;
    logic [31:0] hunt_data = 32'h0;

    t_rx_item bytes_pending[$];
    t_reply   replies_due[$];
    int       n_queued = 0;
    int       bytes_taken = 0;
    int       mismatches = 0;
    logic     rx_hold = 1'b0;

    // Sender and receiver idling state
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_wait = 0;
    int rx_calm = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // CRC8 over one byte, poly 0x07, bit 0 of the byte first
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] c;
        c = acc;
        for (int k = 0; k < 8; k++)
            c = {c[6:0], 1'b0} ^ ((c[7] ^ din[k]) ? CRC_POLY : 8'h00);
        return c;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Dropped candidate: a sync byte immediately opens a new one
    task automatic restart_hunt(input logic [7:0] b);
        hunt_len  = POS_HUNT;
        hunt_crc  = 8'h00;
        hunt_data = 32'h0;
        if (b == cfg_sync) begin
            hunt_len = POS_ADDRESS;
            hunt_crc = crc8_next(8'h00, b);
        end
    endtask

    // Fold one accepted byte into the hunt; a closing CRC byte yields a reply
    task automatic advance_hunt(input logic [7:0] b, input logic req);
        t_reply r;
        if (req) begin
            hunt_len  = POS_HUNT;
            hunt_crc  = 8'h00;
            hunt_data = 32'h0;
        end
        case (hunt_len)
            POS_HUNT: begin
                if (b == cfg_sync) begin
                    hunt_len  = POS_ADDRESS;
                    hunt_crc  = crc8_next(8'h00, b);
                    hunt_data = 32'h0;
                end
            end
            POS_ADDRESS: begin
                if (b == cfg_master) begin
                    hunt_crc = crc8_next(hunt_crc, b);
                    hunt_len = POS_REG;
                end else begin
                    restart_hunt(b);
                end
            end
            POS_REG: begin
                if (b == {1'b0, cfg_reg}) begin
                    hunt_crc = crc8_next(hunt_crc, b);
                    hunt_len = hunt_len + 3'd1;
                end else begin
                    restart_hunt(b);
                end
            end
            POS_CRC: begin
                r.status  = (b == hunt_crc) ? STATUS_OK : STATUS_CRC_ERR;
                r.value   = hunt_data;
                replies_due.push_back(r);
                hunt_len  = POS_HUNT;
                hunt_crc  = 8'h00;
                hunt_data = 32'h0;
            end
            default: begin
                hunt_crc  = crc8_next(hunt_crc, b);
                hunt_data = {hunt_data[23:0], b};
                hunt_len  = hunt_len + 3'd1;
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic req);
        t_rx_item it;
        it.b   = b;
        it.req = req;
        bytes_pending.push_back(it);
        n_queued++;
    endtask

    // Queue the first cut bytes of a datagram for the current settings;
    // new_request is raised on byte req_at (-1 for none)
    task automatic push_frame(input logic [31:0] data, input bit bad_crc, input int cut,
                              input int req_at);
        logic [7:0] frame [8];
        logic [7:0] crc;
        frame[0] = cfg_sync;
        frame[1] = cfg_master;
        frame[2] = {1'b0, cfg_reg};
        frame[3] = data[31:24];
        frame[4] = data[23:16];
        frame[5] = data[15:8];
        frame[6] = data[7:0];
        crc = 8'h00;
        for (int i = 0; i < 7; i++)
            crc = crc8_next(crc, frame[i]);
        frame[7] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
        for (int i = 0; i < cut; i++)
            push_byte(frame[i], i == req_at);
    endtask

    function automatic logic [31:0] pick_data();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return 32'h0000_0000;
        else if (pick < 16)
            return 32'hFFFF_FFFF;
        else if (pick < 24)
            return {4{cfg_sync}};
        return $urandom;
    endfunction

    // Random stream: mostly whole datagrams, mixed with broken ones and noise
    task automatic fill_random(input int count);
        int target;
        int pick;
        logic [7:0] b;
        target = n_queued + count;
        while (n_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                push_frame(pick_data(), $urandom_range(0, 3) == 0, 8,
                           ($urandom_range(0, 4) == 0) ? 0 : -1);
            end else if (pick < 65) begin
                // truncated candidate
                push_frame(pick_data(), 1'b0, $urandom_range(1, 7), -1);
            end else if (pick < 72) begin
                // wrong address byte, often itself a sync byte
                push_byte(cfg_sync, 1'b0);
                b = 8'($urandom);
                if ($urandom_range(0, 1) == 1 && cfg_sync != cfg_master)
                    b = cfg_sync;
                else if (b == cfg_master)
                    b = b ^ 8'h01;
                push_byte(b, 1'b0);
            end else if (pick < 78) begin
                // wrong register byte, top bit sometimes set
                push_byte(cfg_sync, 1'b0);
                push_byte(cfg_master, 1'b0);
                b = 8'($urandom);
                if (b == {1'b0, cfg_reg})
                    b = b ^ 8'h80;
                push_byte(b, 1'b0);
            end else if (pick < 85) begin
                // new request in the middle of a candidate
                push_frame(pick_data(), 1'b0, 8, $urandom_range(1, 7));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_SYNC_BYTE:      cfg_sync = data;
            CFG_MASTER_ADDRESS: cfg_master = data;
            CFG_EXPECTED_REG:   cfg_reg = data[6:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] sync_v, input logic [7:0] master_v,
                              input logic [7:0] reg_v);
        write_reg(CFG_SYNC_BYTE, sync_v);
        write_reg(CFG_MASTER_ADDRESS, master_v);
        write_reg(CFG_EXPECTED_REG, reg_v);
    endtask

    // Wait for the sender to run dry and the replies to arrive, then let the
    // pipeline settle; sampled at the falling edge to avoid edge races
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge i_clk);
        while (bytes_pending.size() != 0 || i_in_valid)
            @(negedge i_clk);
        while (replies_due.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    // Byte sender and predictor hook
    always @(posedge i_clk) begin : send_proc
        t_rx_item cur;
        int       pick;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_hunt(i_rx_byte, i_new_request);
                bytes_taken <= bytes_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (bytes_pending.size() > 0) begin
                    cur = bytes_pending.pop_front();
                    i_rx_byte     <= cur.b;
                    i_new_request <= cur.req;
                    i_in_valid    <= 1'b1;
                    // gap before the next item
                    pick = $urandom_range(0, 99);
                    if (tx_calm > 0)
                        tx_calm--;
                    else if (pick < 4)
                        tx_calm = $urandom_range(20, 60);
                    else if (pick >= 96)
                        tx_gap = $urandom_range(10, 40);
                    else if (pick >= 55)
                        tx_gap = $urandom_range(1, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Reply checker and receiver stall
    always @(posedge i_clk) begin : reply_proc
        t_reply want;
        int     pick;
        logic   stall_now;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    note_mismatch($sformatf("reply with none due: status %0b value %08h",
                                            o_reply_status, o_reg_value));
                end else begin
                    want = replies_due.pop_front();
                    if (o_reply_status !== want.status)
                        note_mismatch($sformatf("reply_status %0b, want %0b",
                                                o_reply_status, want.status));
                    if (o_reg_value !== want.value)
                        note_mismatch($sformatf("reg_value %08h, want %08h",
                                                o_reg_value, want.value));
                end
            end
            if (rx_wait > 0) begin
                rx_wait--;
                stall_now = 1'b1;
            end else if (rx_calm > 0) begin
                rx_calm--;
                stall_now = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                stall_now = (pick >= 60);
                if (pick >= 97)
                    rx_wait = $urandom_range(10, 30);
                else if (pick >= 80)
                    rx_wait = $urandom_range(1, 3);
                else if (pick < 5)
                    rx_calm = $urandom_range(20, 60);
            end
            i_out_stall <= stall_now || rx_hold;
        end
    end

    // Long receiver hold-off mid-stream so the block backs up into its input
    initial begin
        wait (bytes_taken >= 150);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus phases
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: sync 05, master FF, register 00
        @(negedge i_clk);
        push_frame(32'h0505_FF00, 1'b0, 8, -1);   // sync value inside data
        push_byte(8'h05, 1'b0);                   // address byte is a sync: restart
        push_byte(8'h05, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);                   // register byte with top bit set
        push_byte(8'h05, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_frame(32'hFFFF_FFFF, 1'b1, 8, 0);    // new request on sync, CRC error
        push_byte(8'h00, 1'b1);
        fill_random(90);
        drain();

        // sync equal to master, all zero
        set_config(8'h00, 8'h00, 8'h00);
        @(negedge i_clk);
        fill_random(80);
        drain();

        // all ones; register write has its top bit dropped
        set_config(8'hFF, 8'hFF, 8'hFF);
        @(negedge i_clk);
        fill_random(80);
        drain();

        set_config(8'hA5, 8'h3C, 8'h55);
        @(negedge i_clk);
        fill_random(80);
        drain();

        set_config(8'($urandom), 8'($urandom), 8'($urandom));
        @(negedge i_clk);
        fill_random(80);
        drain();

        set_config(8'h7E, 8'h81, 8'h2A);
        @(negedge i_clk);
        fill_random(80);
        drain();

        repeat (10) @(posedge i_clk);
        while (replies_due.size() != 0) begin
            note_mismatch($sformatf("reply never arrived: value %08h",
                                    replies_due[0].value));
            void'(replies_due.pop_front());
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
